// ===== hdl/scpl_pkg.sv =====
// ----------------------------------------------------------------------------
// Second-chance page list package
// Shared sizes, codes and store interface types for the page list unit.
// ----------------------------------------------------------------------------
package scpl_pkg;

  localparam int CAPACITY  = 256;
  localparam int PAGE_BITS = 52;
  localparam int SLOT_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int CMD_W     = 3;
  localparam int STAT_W    = 3;

  localparam logic [CMD_W-1:0] CMD_INS_HEAD   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_TAIL   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TOUCH      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_EVICT_HEAD = 3'd3;
  localparam logic [CMD_W-1:0] CMD_EVICT_SC   = 3'd4;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FULL      = 3'd3,
    ST_DUP       = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_LAST,
    S_DECIDE,
    S_RD,
    S_UPD,
    S_LINK_A,
    S_LINK_B
  } fsm_e;

  typedef struct packed {
    logic [SLOT_W-1:0]    rd_addr;
    logic                 ent_we;
    logic [SLOT_W-1:0]    ent_addr;
    logic [PAGE_BITS-1:0] ent_page;
    logic                 ent_pf;
    logic                 rf_we;
    logic [SLOT_W-1:0]    rf_addr;
    logic                 rf_data;
    logic                 nx_we;
    logic [SLOT_W-1:0]    nx_addr;
    logic [SLOT_W-1:0]    nx_data;
    logic                 pv_we;
    logic [SLOT_W-1:0]    pv_addr;
    logic [SLOT_W-1:0]    pv_data;
  } store_req_t;

  typedef struct packed {
    logic [PAGE_BITS-1:0] page;
    logic                 pf;
    logic                 rf;
    logic [SLOT_W-1:0]    nx;
    logic [SLOT_W-1:0]    pv;
  } store_rsp_t;

endpackage

// ===== hdl/scpl_if.sv =====
// ----------------------------------------------------------------------------
// Second-chance page list channels
// Command and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface scpl_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [scpl_pkg::CMD_W-1:0]     command;
  logic [scpl_pkg::PAGE_BITS-1:0] page_number;
  logic                           prefetched_in;
  logic                           referenced_in;

  modport source (output valid, command, page_number, prefetched_in, referenced_in,
                  input ready);
  modport sink   (input valid, command, page_number, prefetched_in, referenced_in,
                  output ready);
endinterface

interface scpl_res_if;
  logic                           valid;
  logic                           ready;
  logic [scpl_pkg::STAT_W-1:0]    status;
  logic                           evicted_valid;
  logic [scpl_pkg::PAGE_BITS-1:0] evicted_page;
  logic                           evicted_prefetched;
  logic                           evicted_referenced;
  logic [scpl_pkg::CNT_W-1:0]     page_count;

  modport source (output valid, status, evicted_valid, evicted_page, evicted_prefetched,
                  evicted_referenced, page_count, input ready);
  modport sink   (input valid, status, evicted_valid, evicted_page, evicted_prefetched,
                  evicted_referenced, page_count, output ready);
endinterface

// ===== hdl/second_chance_page_lru_list_unit.sv =====
// ----------------------------------------------------------------------------
// Second-chance page list unit
// Recency list of page frames with touch, head eviction and second chance.
// ----------------------------------------------------------------------------
// One command word is taken at a time. Insert and touch find the page by a
// scan of all CAPACITY slots through one page comparator, one slot per clock.
// Inserts and touches finish the scan before they link, move or reject a page.
// Evict head reads the head slot and unlinks it; an eviction from an empty
// list or an unknown command is answered straight from the idle state. Second
// chance clears the bit of every referenced tail page and rotates it to the
// head, paced by the single port of each link memory, or only clears the bit
// when that page is alone in the list.
// The result word sits in an output register; the next command word is taken once
// that result has been taken. No clearing pass follows reset.
module second_chance_page_lru_list_unit (
  input  logic    clk_i,
  input  logic    rst_ni,
  scpl_cmd_if.sink   cmd_i,
  scpl_res_if.source res_o
);
  import scpl_pkg::*;

  fsm_e state_q, state_d;

  logic [CMD_W-1:0]     cmd_q, cmd_d;
  logic [PAGE_BITS-1:0] pg_q, pg_d;
  logic                 pf_q, pf_d, rf_q, rf_d;
  logic [SLOT_W-1:0]    idx_q, idx_d;
  logic                 chk_v_q, chk_v_d;
  logic [SLOT_W-1:0]    chk_idx_q, chk_idx_d;
  logic                 found_q, found_d;
  logic [SLOT_W-1:0]    fslot_q, fslot_d;
  logic                 free_found_q, free_found_d;
  logic [SLOT_W-1:0]    free_q, free_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic [SLOT_W-1:0]    head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W:0]       steps_q, steps_d;
  logic [CAPACITY-1:0]  used_q, used_d;

  logic                 out_v_q;
  logic [STAT_W-1:0]    res_st_q;
  logic                 res_ev_q;
  logic [PAGE_BITS-1:0] res_pg_q;
  logic                 res_pf_q, res_rf_q;
  logic [CNT_W-1:0]     res_cnt_q;

  logic                 fin;
  status_e              fin_st;
  logic                 fin_ev;
  logic [PAGE_BITS-1:0] fin_pg;
  logic                 fin_pf, fin_rf;

  store_req_t req;
  store_rsp_t rsp;

  logic acc, is_ins, at_head, sc_loop, sole;

  scpl_store u_store (
    .clk_i (clk_i),
    .req_i (req),
    .rsp_o (rsp)
  );

  assign acc     = cmd_i.valid && cmd_i.ready;
  assign is_ins  = (cmd_q == CMD_INS_HEAD) || (cmd_q == CMD_INS_TAIL);
  assign at_head = (cmd_q != CMD_INS_TAIL);
  assign sc_loop = (cmd_q == CMD_EVICT_SC) && rsp.rf && (steps_q <= {1'b0, count_q});
  assign sole    = is_ins && (count_q == '0);

  assign cmd_i.ready = (state_q == S_IDLE) && !out_v_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          unique case (cmd_i.command)
            CMD_INS_HEAD, CMD_INS_TAIL, CMD_TOUCH: state_d = S_SCAN;
            CMD_EVICT_HEAD, CMD_EVICT_SC: begin
              if (count_q != '0) state_d = S_RD;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (idx_q == SLOT_W'(CAPACITY - 1)) state_d = S_SCAN_LAST;
      end
      S_SCAN_LAST: state_d = S_DECIDE;
      S_DECIDE: begin
        if (is_ins) begin
          if (!found_q && count_q != CNT_W'(CAPACITY)) state_d = S_LINK_A;
          else state_d = S_IDLE;
        end else if (found_q && fslot_q != head_q) begin
          state_d = S_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RD: state_d = S_UPD;
      S_UPD: begin
        if (cmd_q == CMD_TOUCH) begin
          state_d = S_LINK_A;
        end else if (sc_loop) begin
          state_d = (slot_q == head_q) ? S_RD : S_LINK_A;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_LINK_A: state_d = sole ? S_IDLE : S_LINK_B;
      S_LINK_B: state_d = (cmd_q == CMD_EVICT_SC) ? S_RD : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and store control.
  always_comb begin
    cmd_d = cmd_q; pg_d = pg_q; pf_d = pf_q; rf_d = rf_q;
    idx_d = idx_q; found_d = found_q; fslot_d = fslot_q;
    free_found_d = free_found_q; free_d = free_q; slot_d = slot_q;
    head_d = head_q; tail_d = tail_q; count_d = count_q; steps_d = steps_q;
    used_d = used_q;
    chk_v_d = (state_q == S_SCAN);
    chk_idx_d = idx_q;
    fin = 1'b0; fin_st = ST_OK; fin_ev = 1'b0; fin_pg = '0; fin_pf = 1'b0; fin_rf = 1'b0;
    req = '0;
    req.rd_addr = slot_q;

    // Comparator of the scan: it sees the slot read in the cycle before.
    if (chk_v_q) begin
      if (used_q[chk_idx_q] && rsp.page == pg_q) begin
        found_d = 1'b1;
        fslot_d = chk_idx_q;
      end
      if (!used_q[chk_idx_q] && !free_found_q) begin
        free_found_d = 1'b1;
        free_d = chk_idx_q;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          cmd_d = cmd_i.command;
          pg_d = cmd_i.page_number;
          pf_d = cmd_i.prefetched_in;
          rf_d = cmd_i.referenced_in;
          idx_d = '0;
          found_d = 1'b0;
          free_found_d = 1'b0;
          steps_d = '0;
          unique case (cmd_i.command)
            CMD_INS_HEAD, CMD_INS_TAIL, CMD_TOUCH: ;
            CMD_EVICT_HEAD: begin
              if (count_q == '0) begin fin = 1'b1; fin_st = ST_EMPTY; end
              else slot_d = head_q;
            end
            CMD_EVICT_SC: begin
              if (count_q == '0) begin fin = 1'b1; fin_st = ST_EMPTY; end
              else slot_d = tail_q;
            end
            default: fin = 1'b1;
          endcase
        end
      end
      S_SCAN: begin
        req.rd_addr = idx_q;
        idx_d = idx_q + 1'b1;
      end
      S_SCAN_LAST: ;
      S_DECIDE: begin
        if (is_ins) begin
          if (found_q) begin
            fin = 1'b1; fin_st = ST_DUP;
          end else if (count_q == CNT_W'(CAPACITY)) begin
            fin = 1'b1; fin_st = ST_FULL;
          end else begin
            req.ent_we = 1'b1; req.ent_addr = free_q;
            req.ent_page = pg_q; req.ent_pf = pf_q;
            req.rf_we = 1'b1; req.rf_addr = free_q; req.rf_data = rf_q;
            used_d[free_q] = 1'b1;
            slot_d = free_q;
          end
        end else if (!found_q) begin
          fin = 1'b1; fin_st = ST_NOT_FOUND;
        end else begin
          req.rf_we = 1'b1; req.rf_addr = fslot_q; req.rf_data = 1'b1;
          slot_d = fslot_q;
          if (fslot_q == head_q) fin = 1'b1;
        end
      end
      S_RD: ;
      S_UPD: begin
        if (sc_loop) begin
          req.rf_we = 1'b1; req.rf_addr = slot_q; req.rf_data = 1'b0;
          steps_d = steps_q + 1'b1;
        end
        // Unlink the slot unless it holds the only page, whether evicted or only with its bit cleared.
        if (!(sc_loop && slot_q == head_q) && count_q > CNT_W'(1)) begin
          if (slot_q == head_q) begin
            head_d = rsp.nx;
          end else if (slot_q == tail_q) begin
            tail_d = rsp.pv;
          end else begin
            req.nx_we = 1'b1; req.nx_addr = rsp.pv; req.nx_data = rsp.nx;
            req.pv_we = 1'b1; req.pv_addr = rsp.nx; req.pv_data = rsp.pv;
          end
        end
        if (cmd_q != CMD_TOUCH && !sc_loop) begin
          fin = 1'b1; fin_ev = 1'b1;
          fin_pg = rsp.page; fin_pf = rsp.pf; fin_rf = rsp.rf;
          used_d[slot_q] = 1'b0;
          count_d = count_q - 1'b1;
        end
      end
      S_LINK_A: begin
        req.nx_we = 1'b1; req.nx_addr = slot_q;
        req.pv_we = 1'b1; req.pv_addr = slot_q;
        if (sole) begin
          req.nx_data = slot_q; req.pv_data = slot_q;
          head_d = slot_q; tail_d = slot_q;
          count_d = count_q + 1'b1;
          fin = 1'b1;
        end else if (at_head) begin
          req.nx_data = head_q; req.pv_data = slot_q;
        end else begin
          req.nx_data = slot_q; req.pv_data = tail_q;
        end
      end
      S_LINK_B: begin
        if (at_head) begin
          req.pv_we = 1'b1; req.pv_addr = head_q; req.pv_data = slot_q;
          head_d = slot_q;
        end else begin
          req.nx_we = 1'b1; req.nx_addr = tail_q; req.nx_data = slot_q;
          tail_d = slot_q;
        end
        if (is_ins) count_d = count_q + 1'b1;
        if (cmd_q == CMD_EVICT_SC) slot_d = tail_q;
        else fin = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      chk_v_q <= 1'b0;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      used_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      chk_v_q <= chk_v_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      used_q  <= used_d;
      if (fin) out_v_q <= 1'b1;
      else if (res_o.ready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; pg_q <= pg_d; pf_q <= pf_d; rf_q <= rf_d;
    idx_q <= idx_d; chk_idx_q <= chk_idx_d;
    found_q <= found_d; fslot_q <= fslot_d;
    free_found_q <= free_found_d; free_q <= free_d;
    slot_q <= slot_d; steps_q <= steps_d;
    if (fin) begin
      res_st_q  <= fin_st;
      res_ev_q  <= fin_ev;
      res_pg_q  <= fin_pg;
      res_pf_q  <= fin_pf;
      res_rf_q  <= fin_rf;
      res_cnt_q <= count_d;
    end
  end

  assign res_o.valid              = out_v_q;
  assign res_o.status             = res_st_q;
  assign res_o.evicted_valid      = res_ev_q;
  assign res_o.evicted_page       = res_pg_q;
  assign res_o.evicted_prefetched = res_pf_q;
  assign res_o.evicted_referenced = res_rf_q;
  assign res_o.page_count         = res_cnt_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("page count exceeds capacity");

  a_used_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ($countones(used_q) == int'(count_q)))
    else $error("occupied slots disagree with page count");

  a_no_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !res_ev_q) |-> (res_pg_q == '0 && !res_pf_q && !res_rf_q))
    else $error("evicted fields set without an eviction");

endmodule

// ===== hdl/scpl_store.sv =====
// ----------------------------------------------------------------------------
// Second-chance page list entry store
// Page, flag and link memories with one shared registered read address.
// ----------------------------------------------------------------------------
module scpl_store (
  input  logic                  clk_i,
  input  scpl_pkg::store_req_t  req_i,
  output scpl_pkg::store_rsp_t  rsp_o
);
  import scpl_pkg::*;

  logic [PAGE_BITS-1:0] page_mem [CAPACITY];
  logic                 pf_mem   [CAPACITY];
  logic                 rf_mem   [CAPACITY];
  logic [SLOT_W-1:0]    nx_mem   [CAPACITY];
  logic [SLOT_W-1:0]    pv_mem   [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (req_i.ent_we) begin
      page_mem[req_i.ent_addr] <= req_i.ent_page;
      pf_mem[req_i.ent_addr]   <= req_i.ent_pf;
    end
    if (req_i.rf_we) begin
      rf_mem[req_i.rf_addr] <= req_i.rf_data;
    end
    if (req_i.nx_we) begin
      nx_mem[req_i.nx_addr] <= req_i.nx_data;
    end
    if (req_i.pv_we) begin
      pv_mem[req_i.pv_addr] <= req_i.pv_data;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_o.page <= page_mem[req_i.rd_addr];
    rsp_o.pf   <= pf_mem[req_i.rd_addr];
    rsp_o.rf   <= rf_mem[req_i.rd_addr];
    rsp_o.nx   <= nx_mem[req_i.rd_addr];
    rsp_o.pv   <= pv_mem[req_i.rd_addr];
  end

endmodule
